// ----- hw/rtl/toy_language_tokenizer_macros.svh -----
// Assertion helpers for the tokenizer.
`ifndef TOY_LANGUAGE_TOKENIZER_MACROS_SVH
`define TOY_LANGUAGE_TOKENIZER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, ignored while reset is asserted.
`define TLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ----- hw/rtl/tlt_pkg.sv -----
`default_nettype none

package tlt_pkg;

    localparam int PREFIX_BYTES = 5;
    localparam int TABLE_SIZE   = 16;

    // Token classes
    localparam logic [3:0] CLS_KEYWORD  = 4'd0;
    localparam logic [3:0] CLS_IDENT    = 4'd1;
    localparam logic [3:0] CLS_NUMBER   = 4'd2;
    localparam logic [3:0] CLS_STRING   = 4'd3;
    localparam logic [3:0] CLS_DOT      = 4'd4;
    localparam logic [3:0] CLS_ASSIGN   = 4'd5;
    localparam logic [3:0] CLS_LPAREN   = 4'd6;
    localparam logic [3:0] CLS_RPAREN   = 4'd7;
    localparam logic [3:0] CLS_BLANK    = 4'd8;
    localparam logic [3:0] CLS_COMMA    = 4'd9;
    localparam logic [3:0] CLS_LBRACKET = 4'd10;
    localparam logic [3:0] CLS_RBRACKET = 4'd11;
    localparam logic [3:0] CLS_NEWLINE  = 4'd12;
    localparam logic [3:0] CLS_ERROR    = 4'd13;
    localparam logic [3:0] CLS_SIGN     = 4'd14;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG     = 3'd1;
    localparam logic [2:0] ERR_INCOMPATIBLE = 3'd2;
    localparam logic [2:0] ERR_DOUBLE_MINUS = 3'd3;
    localparam logic [2:0] ERR_LONE_MINUS   = 3'd4;
    localparam logic [2:0] ERR_ILLEGAL      = 3'd5;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd6;

    // Characters with a role of their own
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    localparam logic [5:0] MAX_WORD_RESET = 6'd20;

    // Keywords, first byte in the low bits, unused entries have length zero
    localparam logic [39:0] KW_PATTERN [TABLE_SIZE] = '{
        40'h00_00_62_75_73,   // sub
        40'h00_00_64_64_61,   // add
        40'h00_00_00_6F_74,   // to
        40'h00_6D_6F_72_66,   // from
        40'h00_00_74_75_6F,   // out
        40'h00_65_76_6F_6D,   // move
        40'h00_70_6F_6F_6C,   // loop
        40'h73_65_6D_69_74,   // times
        40'h00_00_74_6E_69,   // int
        40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0
    };
    localparam logic [2:0] KW_LENGTH [TABLE_SIZE] = '{
        3'd3, 3'd3, 3'd2, 3'd4, 3'd3, 3'd4, 3'd4, 3'd5, 3'd3,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    typedef struct packed {
        logic [3:0]  token_class;
        logic [7:0]  token_length;
        logic [3:0]  keyword_index;
        logic [2:0]  error_code;
        logic [15:0] keyword_total;
        logic [15:0] identifier_total;
        logic [15:0] paren_total;
        logic [15:0] dot_total;
    } tlt_result_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [3:0] punct_class(input logic [7:0] c);
        logic [3:0] r;
        case (c)
            8'h2E:   r = CLS_DOT;
            8'h3D:   r = CLS_ASSIGN;
            8'h28:   r = CLS_LPAREN;
            8'h29:   r = CLS_RPAREN;
            8'h20:   r = CLS_BLANK;
            8'h2C:   r = CLS_COMMA;
            8'h5B:   r = CLS_LBRACKET;
            8'h5D:   r = CLS_RBRACKET;
            8'h0A:   r = CLS_NEWLINE;
            default: r = CLS_ERROR;
        endcase
        return r;
    endfunction

    // Does byte c continue a pending token of class cls?
    function automatic logic extends_token(input logic [3:0] cls, input logic [7:0] c);
        logic r;
        if (cls == CLS_IDENT || cls == CLS_NUMBER)
            r = is_letter(c) || is_digit(c);
        else if (c == CH_MINUS || c == CH_QUOTE || is_letter(c) || is_digit(c))
            r = 1'b0;
        else
            r = (punct_class(c) == cls);
        return r;
    endfunction

    // Place byte c at position len of the word prefix while it fits.
    function automatic logic [39:0] prefix_put(input logic [39:0] prefix,
                                               input logic [7:0] len,
                                               input logic [7:0] c);
        logic [39:0] r;
        r = prefix;
        for (int j = 0; j < PREFIX_BYTES; j++)
            if (len == 8'(j))
                r[8*j +: 8] = c;
        return r;
    endfunction

    function automatic logic [7:0] len_inc(input logic [7:0] len);
        return (&len) ? len : len + 8'd1;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tlt_if.sv -----
`default_nettype none

// Source byte channel
interface tlt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

// Token record channel
interface tlt_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_class;
    logic [7:0]  token_length;
    logic [3:0]  keyword_index;
    logic [2:0]  error_code;
    logic [15:0] keyword_total;
    logic [15:0] identifier_total;
    logic [15:0] paren_total;
    logic [15:0] dot_total;

    modport source (output valid, output token_class, output token_length,
                    output keyword_index, output error_code, output keyword_total,
                    output identifier_total, output paren_total, output dot_total,
                    input ready);
    modport sink   (input valid, input token_class, input token_length,
                    input keyword_index, input error_code, input keyword_total,
                    input identifier_total, input paren_total, input dot_total,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/toy_language_tokenizer.sv -----
// Streaming tokenizer: one source byte per item on char_in, at most one token
// record per item on token_out, issued when a token closes. The block takes a
// new item every clock cycle while char_in.ready is high, and registers the
// record for the byte that closes a token in the output stage. A two-deep
// output stage (result register plus skid register) lets input keep flowing
// while one record waits, so char_in.ready drops only when both are full.
// Brace comments are removed, runs of equal punctuation merge, words that
// equal a keyword exactly become keywords, and all error cases close as class
// 13 with a code. Raising end_of_input flushes the pending token and clears
// token state; running totals are kept. The max_word_length register is
// written through cfg_we/cfg_wdata and must only change while the block is
// idle. No clearing pass follows reset.
`default_nettype none

`include "toy_language_tokenizer_macros.svh"

module toy_language_tokenizer
    import tlt_pkg::*;
#(
    parameter int KEYWORD_COUNT = 9,
    parameter int COUNT_WIDTH   = 16
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata,
    tlt_char_if.sink        char_in,
    tlt_token_if.source     token_out
);

    // Configuration
    logic [5:0] max_word_reg;

    // Token state
    logic [3:0]  pend_class_reg, pend_class_next;
    logic [7:0]  pend_len_reg,   pend_len_next;
    logic [39:0] prefix_reg,     prefix_next;
    logic        in_comment_reg, in_comment_next;
    logic        in_string_reg,  in_string_next;
    logic        minus_reg,      minus_next;
    logic        num_bad_reg,    num_bad_next;

    // Running totals
    logic [COUNT_WIDTH-1:0] kw_cnt_reg,    kw_cnt_next;
    logic [COUNT_WIDTH-1:0] id_cnt_reg,    id_cnt_next;
    logic [COUNT_WIDTH-1:0] paren_cnt_reg, paren_cnt_next;
    logic [COUNT_WIDTH-1:0] dot_cnt_reg,   dot_cnt_next;

    // Output stage
    logic        out_valid_reg;
    tlt_result_t out_reg;
    logic        skid_valid_reg;
    tlt_result_t skid_reg;

    logic        fire;
    logic        out_pop;
    logic [7:0]  c;

    // Closing the pending token, from state only
    logic        kw_hit;
    logic [3:0]  kw_idx;
    logic [3:0]  close_class;
    logic [3:0]  close_kw;
    logic [2:0]  close_err;
    logic        close_bump_kw, close_bump_id, close_bump_paren, close_bump_dot;

    // Result of this item
    logic        res_valid;
    tlt_result_t res;
    logic        do_close;
    logic        do_start;

    logic [COUNT_WIDTH+15:0] kw_ext, id_ext, paren_ext, dot_ext;

    assign c        = char_in.char_code;
    assign fire     = char_in.valid && char_in.ready;
    assign out_pop  = out_valid_reg && token_out.ready;
    assign char_in.ready = !skid_valid_reg;

    // Whole-word keyword compare over the first five bytes
    always_comb
    begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int i = 0; i < KEYWORD_COUNT && i < TABLE_SIZE; i++)
        begin
            if (!kw_hit && KW_LENGTH[i] != 3'd0 && pend_len_reg == {5'd0, KW_LENGTH[i]}
                && prefix_reg == KW_PATTERN[i])
            begin
                kw_hit = 1'b1;
                kw_idx = 4'(i);
            end
        end
    end

    // Judge the pending token as it would close now
    always_comb
    begin
        close_class      = pend_class_reg;
        close_kw         = '0;
        close_err        = ERR_NONE;
        close_bump_kw    = 1'b0;
        close_bump_id    = 1'b0;
        close_bump_paren = 1'b0;
        close_bump_dot   = 1'b0;
        if (pend_class_reg == CLS_IDENT)
        begin
            if (pend_len_reg > {2'b00, max_word_reg})
            begin
                close_class = CLS_ERROR;
                close_err   = ERR_TOO_LONG;
            end
            else if (kw_hit)
            begin
                close_class   = CLS_KEYWORD;
                close_kw      = kw_idx;
                close_bump_kw = 1'b1;
            end
            else
            begin
                close_bump_id = 1'b1;
            end
        end
        else if (pend_class_reg == CLS_NUMBER)
        begin
            if (num_bad_reg)
            begin
                close_class = CLS_ERROR;
                close_err   = ERR_INCOMPATIBLE;
            end
        end
        else if (pend_class_reg == CLS_ERROR)
        begin
            close_err = ERR_ILLEGAL;
        end
        else if (pend_class_reg == CLS_DOT)
        begin
            close_bump_dot = 1'b1;
        end
        else if (pend_class_reg == CLS_LPAREN || pend_class_reg == CLS_RPAREN)
        begin
            close_bump_paren = 1'b1;
        end
    end

    // Next token state and the record this item produces
    always_comb
    begin
        pend_class_next = pend_class_reg;
        pend_len_next   = pend_len_reg;
        prefix_next     = prefix_reg;
        in_comment_next = in_comment_reg;
        in_string_next  = in_string_reg;
        minus_next      = minus_reg;
        num_bad_next    = num_bad_reg;
        kw_cnt_next     = kw_cnt_reg;
        id_cnt_next     = id_cnt_reg;
        paren_cnt_next  = paren_cnt_reg;
        dot_cnt_next    = dot_cnt_reg;
        res_valid       = 1'b0;
        res             = '0;
        do_close        = 1'b0;
        do_start        = 1'b0;

        if (char_in.end_of_input)
        begin
            if (in_string_reg)
            begin
                res_valid         = 1'b1;
                res.token_class   = CLS_ERROR;
                res.token_length  = pend_len_reg;
                res.error_code    = ERR_UNTERMINATED;
            end
            else if (minus_reg)
            begin
                res_valid         = 1'b1;
                res.token_class   = CLS_ERROR;
                res.token_length  = 8'd1;
                res.error_code    = ERR_LONE_MINUS;
            end
            else if (pend_len_reg != 8'd0)
            begin
                do_close = 1'b1;
            end
            pend_class_next = CLS_BLANK;
            pend_len_next   = '0;
            prefix_next     = '0;
            in_comment_next = 1'b0;
            in_string_next  = 1'b0;
            minus_next      = 1'b0;
            num_bad_next    = 1'b0;
        end
        else if (in_comment_reg)
        begin
            if (c == CH_RBRACE)
                in_comment_next = 1'b0;
        end
        else if (in_string_reg)
        begin
            prefix_next   = prefix_put(prefix_reg, pend_len_reg, c);
            pend_len_next = len_inc(pend_len_reg);
            if (c == CH_QUOTE)
            begin
                res_valid        = 1'b1;
                res.token_class  = CLS_STRING;
                res.token_length = pend_len_next;
                in_string_next   = 1'b0;
                pend_class_next  = CLS_BLANK;
                pend_len_next    = '0;
                prefix_next      = '0;
            end
        end
        else if (c == CH_LBRACE)
        begin
            in_comment_next = 1'b1;
        end
        else if (minus_reg)
        begin
            res_valid = 1'b1;
            if (c == CH_MINUS)
            begin
                // second minus stays pending
                res.token_class  = CLS_ERROR;
                res.token_length = 8'd2;
                res.error_code   = ERR_DOUBLE_MINUS;
            end
            else
            begin
                minus_next       = 1'b0;
                res.token_length = 8'd1;
                if (is_digit(c))
                begin
                    res.token_class = CLS_SIGN;
                end
                else
                begin
                    res.token_class = CLS_ERROR;
                    res.error_code  = ERR_LONE_MINUS;
                end
                do_start = 1'b1;
            end
        end
        else if (pend_len_reg != 8'd0)
        begin
            if (extends_token(pend_class_reg, c))
            begin
                if (pend_class_reg == CLS_NUMBER && is_letter(c))
                    num_bad_next = 1'b1;
                prefix_next   = prefix_put(prefix_reg, pend_len_reg, c);
                pend_len_next = len_inc(pend_len_reg);
            end
            else
            begin
                do_close = 1'b1;
                do_start = 1'b1;
            end
        end
        else
        begin
            do_start = 1'b1;
        end

        // Emit the pending token and bump its total
        if (do_close)
        begin
            res_valid         = 1'b1;
            res.token_class   = close_class;
            res.token_length  = pend_len_reg;
            res.keyword_index = close_kw;
            res.error_code    = close_err;
            if (close_bump_kw && !(&kw_cnt_reg))
                kw_cnt_next = kw_cnt_reg + 1'b1;
            if (close_bump_id && !(&id_cnt_reg))
                id_cnt_next = id_cnt_reg + 1'b1;
            if (close_bump_paren && !(&paren_cnt_reg))
                paren_cnt_next = paren_cnt_reg + 1'b1;
            if (close_bump_dot && !(&dot_cnt_reg))
                dot_cnt_next = dot_cnt_reg + 1'b1;
            pend_class_next = CLS_BLANK;
            pend_len_next   = '0;
            prefix_next     = '0;
            num_bad_next    = 1'b0;
        end

        // Open a new token with this byte
        if (do_start)
        begin
            prefix_next  = '0;
            num_bad_next = 1'b0;
            if (c == CH_MINUS)
            begin
                minus_next      = 1'b1;
                pend_class_next = CLS_BLANK;
                pend_len_next   = '0;
            end
            else
            begin
                if (c == CH_QUOTE)
                begin
                    in_string_next  = 1'b1;
                    pend_class_next = CLS_STRING;
                end
                else if (is_letter(c))
                    pend_class_next = CLS_IDENT;
                else if (is_digit(c))
                    pend_class_next = CLS_NUMBER;
                else
                    pend_class_next = punct_class(c);
                prefix_next   = {32'd0, c};
                pend_len_next = 8'd1;
            end
        end

        // Totals ride along, truncated or widened to the port width
        kw_ext    = {16'd0, kw_cnt_next};
        id_ext    = {16'd0, id_cnt_next};
        paren_ext = {16'd0, paren_cnt_next};
        dot_ext   = {16'd0, dot_cnt_next};
        res.keyword_total    = kw_ext[15:0];
        res.identifier_total = id_ext[15:0];
        res.paren_total      = paren_ext[15:0];
        res.dot_total        = dot_ext[15:0];
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_word_reg <= MAX_WORD_RESET;
        else if (cfg_we)
            max_word_reg <= cfg_wdata;
    end

    // Advance token state on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_class_reg <= CLS_BLANK;
            pend_len_reg   <= '0;
            prefix_reg     <= '0;
            in_comment_reg <= 1'b0;
            in_string_reg  <= 1'b0;
            minus_reg      <= 1'b0;
            num_bad_reg    <= 1'b0;
            kw_cnt_reg     <= '0;
            id_cnt_reg     <= '0;
            paren_cnt_reg  <= '0;
            dot_cnt_reg    <= '0;
        end
        else if (fire)
        begin
            pend_class_reg <= pend_class_next;
            pend_len_reg   <= pend_len_next;
            prefix_reg     <= prefix_next;
            in_comment_reg <= in_comment_next;
            in_string_reg  <= in_string_next;
            minus_reg      <= minus_next;
            num_bad_reg    <= num_bad_next;
            kw_cnt_reg     <= kw_cnt_next;
            id_cnt_reg     <= id_cnt_next;
            paren_cnt_reg  <= paren_cnt_next;
            dot_cnt_reg    <= dot_cnt_next;
        end
    end

    // Output stage valid bits: the skid register fills only when the
    // result register holds a record that is not taken this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
                skid_valid_reg <= 1'b0;
        end
        else if (fire && res_valid)
        begin
            if (out_valid_reg && !out_pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
                out_reg <= skid_reg;
        end
        else if (fire && res_valid)
        begin
            if (out_valid_reg && !out_pop)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign token_out.valid            = out_valid_reg;
    assign token_out.token_class      = out_reg.token_class;
    assign token_out.token_length     = out_reg.token_length;
    assign token_out.keyword_index    = out_reg.keyword_index;
    assign token_out.error_code       = out_reg.error_code;
    assign token_out.keyword_total    = out_reg.keyword_total;
    assign token_out.identifier_total = out_reg.identifier_total;
    assign token_out.paren_total      = out_reg.paren_total;
    assign token_out.dot_total        = out_reg.dot_total;

    // The skid register holds a record only behind a full result register
    `TLT_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // A pending minus never coexists with pending token text
    `TLT_ASSERT_NOW(a_minus_alone, clk, rst_n, minus_reg, pend_len_reg == 8'd0 && !in_string_reg)
    // Strings and comments exclude each other
    `TLT_ASSERT_NOW(a_string_no_comment, clk, rst_n, in_string_reg, !in_comment_reg)
    // End of text leaves no open token state behind
    `TLT_ASSERT_NEXT(a_flush_clears, clk, rst_n, fire && char_in.end_of_input,
        pend_len_reg == 8'd0 && !minus_reg && !in_comment_reg && !in_string_reg)

endmodule

`default_nettype wire
